// ===== rtl/spg_pkg.sv =====
// Shared constants, types and helpers of the Sobol point generator.
package spg_pkg;

	localparam int NUM_DIMS   = 8;
	localparam int WORD_BITS  = 32;
	localparam int MAX_DEGREE = 18;

	localparam int DIM_W   = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;
	localparam int CNT_W   = $clog2(NUM_DIMS + 1);
	localparam int BIT_W   = $clog2(WORD_BITS);
	localparam int DEG_W   = 5;
	localparam int COEFF_W = 17;
	localparam int INIT_W  = 18;
	localparam int REQ_W   = 3;
	localparam int SEL_W   = 3;
	localparam int IDX_W   = 5;
	localparam int SKIP_W  = 32;
	localparam int COORD_W = 32;

	localparam logic [REQ_W-1:0] REQ_SET_POLY   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_LOAD_INIT  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_BUILD      = 3'd2;
	localparam logic [REQ_W-1:0] REQ_NEXT_POINT = 3'd3;
	localparam logic [REQ_W-1:0] REQ_SKIP       = 3'd4;

	// register index, taken from paddr[2]
	localparam logic REG_DIMS_IN_USE = 1'b0;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [BIT_W-1:0]     bit_idx_t;
	typedef logic [DIM_W-1:0]     dim_idx_t;
	typedef logic [CNT_W-1:0]     dim_cnt_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_SET,
		OP_LOAD,
		OP_BUILD,
		OP_NEXT,
		OP_SKIP_CLR,
		OP_SKIP_STEP,
		OP_SHIFT
	} cell_op_t;

	typedef struct packed {
		cell_op_t           op;
		dim_idx_t           sel;
		logic               dim_ok;
		logic [DEG_W-1:0]   degree;
		logic [COEFF_W-1:0] coeff;
		logic               idx_ok;
		bit_idx_t           idx;
		logic [INIT_W-1:0]  init;
		bit_idx_t           rd_addr;
		logic               gray_bit;
		logic               advance;
	} cell_cmd_t;

	// fixed direction numbers of dimension 0
	function automatic word_t fixed_dir(bit_idx_t a);
		fixed_dir = word_t'(1) << (WORD_BITS - 1 - int'(a));
	endfunction

endpackage

// ===== rtl/spg_req_if.sv =====
// Request channel of the Sobol point generator.
interface spg_req_if import spg_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [REQ_W-1:0]   req_type;
	logic [SEL_W-1:0]   dim_select;
	logic [DEG_W-1:0]   poly_degree;
	logic [COEFF_W-1:0] poly_coeff;
	logic [IDX_W-1:0]   init_index;
	logic [INIT_W-1:0]  init_value;
	logic [SKIP_W-1:0]  skip_amount;

	modport source (output valid, output req_type, output dim_select, output poly_degree,
		output poly_coeff, output init_index, output init_value, output skip_amount,
		input ready);
	modport sink (input valid, input req_type, input dim_select, input poly_degree,
		input poly_coeff, input init_index, input init_value, input skip_amount,
		output ready);
endinterface

// ===== rtl/spg_res_if.sv =====
// Result channel of the Sobol point generator.
interface spg_res_if import spg_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [SEL_W-1:0]   dim_out;
	logic [COORD_W-1:0] coordinate;
	logic               exhausted;
	logic               last_of_point;

	modport source (output valid, output dim_out, output coordinate, output exhausted,
		output last_of_point, input ready);
	modport sink (input valid, input dim_out, input coordinate, input exhausted,
		input last_of_point, output ready);
endinterface

// ===== rtl/spg_cell.sv =====
// One dimension: direction numbers, build sequencer, coordinate and output shift stage.
module spg_cell import spg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  dim_idx_t  cell_id,
	input  cell_cmd_t cmd,
	input  word_t     sh_in,
	output word_t     sh_out,
	output logic      busy
);

	word_t              v_q [WORD_BITS];
	word_t              x_q;
	word_t              sh_q;
	word_t              acc_q;
	word_t              rd;
	word_t              term;
	word_t              acc_next;
	word_t              x_nxt;
	logic [DEG_W-1:0]   deg_q;
	logic [DEG_W-1:0]   s_eff;
	logic [DEG_W-1:0]   bk_q;
	logic [DEG_W-1:0]   cb;
	logic [COEFF_W-1:0] coeff_q;
	bit_idx_t           bi_q;
	bit_idx_t           ra;
	logic               busy_q;
	logic               hit;

	always_comb begin
		hit   = cmd.dim_ok && (cmd.sel == cell_id);
		s_eff = (deg_q > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : deg_q;
		ra    = busy_q ? bit_idx_t'(bi_q - bit_idx_t'(bk_q)) : cmd.rd_addr;
		rd    = (cell_id == '0) ? fixed_dir(ra) : v_q[ra];
		cb    = s_eff - bk_q - DEG_W'(1);
		if (bk_q == s_eff) begin
			term = rd ^ (rd >> s_eff);
		end else if ((cb < DEG_W'(COEFF_W)) && coeff_q[cb]) begin
			term = rd;
		end else begin
			term = '0;
		end
		acc_next = (bk_q == s_eff) ? term : (acc_q ^ term);
		x_nxt    = cmd.advance ? (x_q ^ rd) : x_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			bi_q    <= '0;
			bk_q    <= '0;
			acc_q   <= '0;
			deg_q   <= '0;
			coeff_q <= '0;
			x_q     <= '0;
			for (int i = 0; i < WORD_BITS; i++) begin
				v_q[i] <= '0;
			end
		end else begin
			// one term of the recurrence per cycle, k from s down to 1
			if (busy_q) begin
				if (bk_q == DEG_W'(1)) begin
					v_q[bi_q] <= acc_next;
					if (bi_q == bit_idx_t'(WORD_BITS - 1)) begin
						busy_q <= 1'b0;
					end else begin
						bi_q <= bi_q + bit_idx_t'(1);
						bk_q <= s_eff;
					end
				end else begin
					bk_q <= bk_q - DEG_W'(1);
				end
				acc_q <= acc_next;
			end
			case (cmd.op)
				OP_SET: begin
					if (hit) begin
						deg_q   <= cmd.degree;
						coeff_q <= cmd.coeff;
					end
				end
				OP_LOAD: begin
					if (hit && cmd.idx_ok) begin
						v_q[cmd.idx] <= word_t'(cmd.init) << (WORD_BITS - 1 - int'(cmd.idx));
					end
				end
				OP_BUILD: begin
					if (hit && (s_eff != '0) && (int'(s_eff) < WORD_BITS)) begin
						busy_q <= 1'b1;
						bi_q   <= bit_idx_t'(s_eff);
						bk_q   <= s_eff;
					end
				end
				OP_NEXT:      x_q <= x_nxt;
				OP_SKIP_CLR:  x_q <= '0;
				OP_SKIP_STEP: begin
					if (cmd.gray_bit) begin
						x_q <= x_q ^ rd;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_NEXT:  sh_q <= x_nxt;
			OP_SHIFT: sh_q <= sh_in;
			default:  ;
		endcase
	end

	assign sh_out = sh_q;
	assign busy   = busy_q;

endmodule

// ===== rtl/spg_cfg.sv =====
// APB register port: dims_in_use.
module spg_cfg import spg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [3:0]  dims_in_use
);

	localparam logic [3:0] DIMS_RESET = 4'd8;

	logic [3:0] dims_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= DIMS_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_DIMS_IN_USE)) begin
			dims_q <= pwdata[3:0];
		end
	end

	assign prdata      = (paddr[2] == REG_DIMS_IN_USE) ? {28'd0, dims_q} : 32'd0;
	assign pready      = 1'b1;
	assign dims_in_use = dims_q;

endmodule

// ===== rtl/sobol_point_generator.sv =====
// Top level of the Sobol point generator: sequencer, cell chain and register port.
//
// Requests enter on req (valid/ready); coordinates leave on res, one result per
// active dimension, dimension 0 first, last_of_point on the final one.
// dims_in_use sits at APB address 0; write it only while the block is idle.
// Set-polynomial and load requests act at acceptance. A build then works through
// the recurrence of degree s (s clamped to MAX_DEGREE) in the addressed cell, one
// term per cycle.
// A next request updates all coordinates at acceptance (lowest-zero add of the
// point count selects the direction number), then shifts the coordinates out of
// the cell chain, one per cycle while res.ready is high.
// A skip sets the count and then works one Gray-code bit per cycle in every cell.
// One request is worked on at a time; req.ready is low until its results are
// all taken. When res.ready is low the chain holds and the current result stays.
// Reset clears the tables, coordinates and count (dimension 0 stays fixed), and
// sets dims_in_use to 8; the block is ready right after reset.
module sobol_point_generator import spg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	spg_req_if.sink     req,
	spg_res_if.source   res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SKIP = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t              st_q;
	word_t               count_q;
	word_t               gray_q;
	word_t               low_zero;
	word_t               target;
	logic [SKIP_W:0]     sum;
	bit_idx_t            c_idx;
	bit_idx_t            j_q;
	dim_cnt_t            emit_q;
	dim_cnt_t            n_q;
	dim_cnt_t            n_act;
	logic                exh;
	logic                exh_q;
	logic                in_acc;
	logic                out_acc;
	logic                any_busy;
	logic [3:0]          dims;
	logic [NUM_DIMS-1:0] busy_w;
	word_t               sh_w [NUM_DIMS+1];
	cell_cmd_t           cmd;

	spg_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.dims_in_use (dims)
	);

	assign sh_w[NUM_DIMS] = '0;

	for (genvar d = 0; d < NUM_DIMS; d++) begin : g_cell
		spg_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cell_id (dim_idx_t'(d)),
			.cmd     (cmd),
			.sh_in   (sh_w[d+1]),
			.sh_out  (sh_w[d]),
			.busy    (busy_w[d])
		);
	end

	assign any_busy  = |busy_w;
	assign req.ready = (st_q == ST_IDLE) && !any_busy;
	assign in_acc    = req.valid && req.ready;
	assign out_acc   = res.valid && res.ready;

	always_comb begin
		low_zero = ~count_q & (count_q + word_t'(1));
		exh      = &count_q;
		c_idx    = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (low_zero[i]) begin
				c_idx = c_idx | bit_idx_t'(i);
			end
		end
		sum    = (SKIP_W+1)'(count_q) + (SKIP_W+1)'(req.skip_amount);
		target = ((sum >> WORD_BITS) != '0) ? '1 : sum[WORD_BITS-1:0];
		if (dims == 4'd0) begin
			n_act = dim_cnt_t'(1);
		end else if (int'(dims) > NUM_DIMS) begin
			n_act = dim_cnt_t'(NUM_DIMS);
		end else begin
			n_act = dim_cnt_t'(dims);
		end
	end

	always_comb begin
		cmd.op       = OP_NONE;
		cmd.sel      = dim_idx_t'(req.dim_select);
		cmd.dim_ok   = (req.dim_select != '0) && (int'(req.dim_select) < NUM_DIMS);
		cmd.degree   = req.poly_degree;
		cmd.coeff    = req.poly_coeff;
		cmd.idx_ok   = (int'(req.init_index) < MAX_DEGREE) &&
			(int'(req.init_index) < WORD_BITS);
		cmd.idx      = bit_idx_t'(req.init_index);
		cmd.init     = req.init_value;
		cmd.rd_addr  = c_idx;
		cmd.gray_bit = 1'b0;
		cmd.advance  = !exh;
		case (st_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (req.req_type)
						REQ_SET_POLY:   cmd.op = OP_SET;
						REQ_LOAD_INIT:  cmd.op = OP_LOAD;
						REQ_BUILD:      cmd.op = OP_BUILD;
						REQ_NEXT_POINT: cmd.op = OP_NEXT;
						REQ_SKIP:       cmd.op = OP_SKIP_CLR;
						default:        cmd.op = OP_NONE;
					endcase
				end
			end
			ST_SKIP: begin
				cmd.op       = OP_SKIP_STEP;
				cmd.rd_addr  = j_q;
				cmd.gray_bit = gray_q[j_q];
			end
			ST_EMIT: begin
				if (out_acc) begin
					cmd.op = OP_SHIFT;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			count_q <= '0;
			gray_q  <= '0;
			j_q     <= '0;
			emit_q  <= '0;
			n_q     <= '0;
			exh_q   <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (req.req_type)
							REQ_NEXT_POINT: begin
								st_q   <= ST_EMIT;
								emit_q <= '0;
								n_q    <= n_act;
								exh_q  <= exh;
								if (!exh) begin
									count_q <= count_q + word_t'(1);
								end
							end
							REQ_SKIP: begin
								st_q    <= ST_SKIP;
								count_q <= target;
								gray_q  <= target ^ (target >> 1);
								j_q     <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_SKIP: begin
					if (j_q == bit_idx_t'(WORD_BITS - 1)) begin
						st_q <= ST_IDLE;
					end else begin
						j_q <= j_q + bit_idx_t'(1);
					end
				end
				ST_EMIT: begin
					if (out_acc) begin
						if (emit_q == n_q - dim_cnt_t'(1)) begin
							st_q <= ST_IDLE;
						end else begin
							emit_q <= emit_q + dim_cnt_t'(1);
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign res.valid         = (st_q == ST_EMIT);
	assign res.dim_out       = SEL_W'(emit_q);
	assign res.coordinate    = COORD_W'(sh_w[0]) << (COORD_W - WORD_BITS);
	assign res.exhausted     = exh_q;
	assign res.last_of_point = (emit_q == n_q - dim_cnt_t'(1));

	a_emit_order: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.ready && !res.last_of_point) |=>
		(res.valid && (res.dim_out == $past(res.dim_out) + 3'd1)))
		else $error("coordinate sequence broken within a point");

	a_saturate: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (req.req_type == REQ_NEXT_POINT) && (&count_q)) |=> (&count_q))
		else $error("point count moved past saturation");

	a_exhausted: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.exhausted) |-> (&count_q))
		else $error("exhausted flag without saturated count");

	a_build_idle: assert property (@(posedge clk) disable iff (!arst_n)
		any_busy |-> (st_q == ST_IDLE))
		else $error("build running outside idle");

endmodule

// ===== tb/sv/tb_sobol_point_generator.sv =====
// Testbench of the Sobol point generator: directed and random requests checked by a scoreboard.
module tb_sobol_point_generator;
	import spg_pkg::*;

	localparam logic [2:0]       ADDR_DIMS_IN_USE = {REG_DIMS_IN_USE, 2'b00};
	localparam logic [REQ_W-1:0] REQ_RSVD_5       = 3'd5;
	localparam logic [REQ_W-1:0] REQ_RSVD_6       = 3'd6;
	localparam logic [REQ_W-1:0] REQ_RSVD_7       = 3'd7;
	localparam logic [63:0]      COUNT_MAX        = 64'hFFFF_FFFF;
	localparam int               SETTLE_CYCLES    = 300;
	localparam int               WATCHDOG_LIMIT   = 5000;
	localparam int               SEG_ITEMS        = 56;

	typedef struct packed {
		logic [REQ_W-1:0]   req_type;
		logic [SEL_W-1:0]   dim_select;
		logic [DEG_W-1:0]   poly_degree;
		logic [COEFF_W-1:0] poly_coeff;
		logic [IDX_W-1:0]   init_index;
		logic [INIT_W-1:0]  init_value;
		logic [SKIP_W-1:0]  skip_amount;
	} sobol_req_t;

	typedef struct packed {
		logic [SEL_W-1:0]   dim;
		logic [COORD_W-1:0] coord;
		logic               exhausted;
		logic               last;
	} coord_item_t;

	class sobol_scoreboard;
		word_t              dir_num [NUM_DIMS][WORD_BITS];
		logic [DEG_W-1:0]   degree [NUM_DIMS];
		logic [COEFF_W-1:0] coeff [NUM_DIMS];
		word_t              coord [NUM_DIMS];
		word_t              count;
		logic [3:0]         dims_reg;
		coord_item_t        pending [$];
		int unsigned        errors;

		function new();
			int d, i;
			for (d = 0; d < NUM_DIMS; d++) begin
				degree[d] = '0;
				coeff[d]  = '0;
				coord[d]  = '0;
				for (i = 0; i < WORD_BITS; i++)
					dir_num[d][i] = (d == 0) ? (word_t'(1) << (WORD_BITS - 1 - i)) : word_t'(0);
			end
			count    = '0;
			dims_reg = 4'd8;
			errors   = 0;
		endfunction

		function void set_dims(input logic [3:0] v);
			dims_reg = v;
		endfunction

		function void build_dim(input int d);
			int s, i, k;
			word_t w;
			s = int'(degree[d]);
			if (s == 0)
				return;
			if (s > MAX_DEGREE)
				s = MAX_DEGREE;
			for (i = s; i < WORD_BITS; i++) begin
				w = dir_num[d][i - s];
				w ^= w >> s;
				for (k = 1; k < s; k++)
					if (coeff[d][s - 1 - k])
						w ^= dir_num[d][i - k];
				dir_num[d][i] = w;
			end
		endfunction

		function void note_request(input sobol_req_t r);
			int d, c, n, j;
			logic [63:0] target, gray;
			word_t x;
			logic dim_ok, exh;
			coord_item_t item;
			dim_ok = (r.dim_select != 0) && (int'(r.dim_select) < NUM_DIMS);
			case (r.req_type)
			REQ_SET_POLY: if (dim_ok) begin
				degree[r.dim_select] = r.poly_degree;
				coeff[r.dim_select]  = r.poly_coeff;
			end
			REQ_LOAD_INIT: if (dim_ok && int'(r.init_index) < MAX_DEGREE &&
					int'(r.init_index) < WORD_BITS) begin
				dir_num[r.dim_select][r.init_index] =
					word_t'(r.init_value) << (WORD_BITS - 1 - int'(r.init_index));
			end
			REQ_BUILD: if (dim_ok) begin
				build_dim(int'(r.dim_select));
			end
			REQ_NEXT_POINT: begin
				c = 0;
				while (c < WORD_BITS && count[c])
					c++;
				exh = (c >= WORD_BITS);
				if (!exh) begin
					for (d = 0; d < NUM_DIMS; d++)
						coord[d] ^= dir_num[d][c];
					count++;
				end
				n = (dims_reg == 0) ? 1 : (dims_reg > NUM_DIMS) ? NUM_DIMS : int'(dims_reg);
				for (d = 0; d < n; d++) begin
					item.dim       = SEL_W'(d);
					item.coord     = coord[d];
					item.exhausted = exh;
					item.last      = (d + 1 == n);
					pending.push_back(item);
				end
			end
			REQ_SKIP: begin
				target = 64'(count) + 64'(r.skip_amount);
				if (target > COUNT_MAX)
					target = COUNT_MAX;
				count = word_t'(target);
				gray  = target ^ (target >> 1);
				for (d = 0; d < NUM_DIMS; d++) begin
					x = '0;
					for (j = 0; j < WORD_BITS; j++)
						if (gray[j])
							x ^= dir_num[d][j];
					coord[d] = x;
				end
			end
			default: ;
			endcase
		endfunction

		function void check_coordinate(input coord_item_t got);
			coord_item_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: dim %0d coord %h exh %b last %b",
						got.dim, got.coord, got.exhausted, got.last);
				return;
			end
			want = pending.pop_front();
			if (got.dim !== want.dim || got.coord !== want.coord ||
					got.exhausted !== want.exhausted || got.last !== want.last) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch: expected dim %0d coord %h exh %b last %b,",
						" got dim %0d coord %h exh %b last %b"},
						want.dim, want.coord, want.exhausted, want.last,
						got.dim, got.coord, got.exhausted, got.last);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	spg_req_if req_ch ();
	spg_res_if res_ch ();

	sobol_scoreboard book;
	coord_item_t     seen;
	int              send_idle_pct;
	int              recv_stall_pct;
	int              hold_left;
	int              idle_cycles;
	int              items_sent;

	sobol_point_generator DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #1 clk = ~clk;

	task automatic send_request(input logic [REQ_W-1:0] kind, input logic [31:0] sel,
		input logic [31:0] deg, input logic [31:0] cf,
		input logic [31:0] idx, input logic [31:0] val,
		input logic [31:0] amt);
		sobol_req_t r;
		r.req_type    = kind;
		r.dim_select  = sel[SEL_W-1:0];
		r.poly_degree = deg[DEG_W-1:0];
		r.poly_coeff  = cf[COEFF_W-1:0];
		r.init_index  = idx[IDX_W-1:0];
		r.init_value  = val[INIT_W-1:0];
		r.skip_amount = amt[SKIP_W-1:0];
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req_ch.valid       <= 1'b1;
		req_ch.req_type    <= r.req_type;
		req_ch.dim_select  <= r.dim_select;
		req_ch.poly_degree <= r.poly_degree;
		req_ch.poly_coeff  <= r.poly_coeff;
		req_ch.init_index  <= r.init_index;
		req_ch.init_value  <= r.init_value;
		req_ch.skip_amount <= r.skip_amount;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		book.note_request(r);
		if (kind <= REQ_SKIP)
			items_sent++;
	endtask

	task automatic next_point();
		send_request(REQ_NEXT_POINT, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic skip_by(input logic [SKIP_W-1:0] amt);
		send_request(REQ_SKIP, $urandom, $urandom, $urandom, $urandom, $urandom, amt);
	endtask

	// stop requesting, wait for every coordinate, then let a build finish
	task automatic settle();
		req_ch.valid <= 1'b0;
		while (book.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		book.set_dims(data[3:0]);
	endtask

	// well-formed setup of one dimension: polynomial, odd initial values, build
	task automatic program_dim();
		int d, deg, i;
		d   = $urandom_range(1, NUM_DIMS - 1);
		deg = ($urandom_range(3) == 0) ? $urandom_range(9, MAX_DEGREE) : $urandom_range(1, 8);
		send_request(REQ_SET_POLY, d, deg, $urandom & ((1 << (deg - 1)) - 1),
			$urandom, $urandom, $urandom);
		for (i = 0; i < deg; i++)
			send_request(REQ_LOAD_INIT, d, $urandom, $urandom, i,
				$urandom_range(0, (1 << (i + 1)) - 1) | 1, $urandom);
		send_request(REQ_BUILD, d, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic run_random(input int quota);
		int stop, pick, k, burst;
		logic [REQ_W-1:0] kind;
		stop = items_sent + quota;
		while (items_sent < stop) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				program_dim();
			end else if (pick < 66) begin
				burst = $urandom_range(1, 6);
				for (k = 0; k < burst; k++)
					next_point();
			end else if (pick < 78) begin
				skip_by($urandom_range(0, 5000));
			end else begin
				// arbitrary request, skips kept short so the count stays clear of the end
				kind = REQ_W'($urandom_range(0, 7));
				send_request(kind, $urandom, $urandom, $urandom, $urandom, $urandom,
					(kind == REQ_SKIP) ? $urandom_range(0, 65535) : $urandom);
			end
		end
	endtask

	always @(posedge clk) begin
		if (res_ch.valid && res_ch.ready) begin
			seen.dim       = res_ch.dim_out;
			seen.coord     = res_ch.coordinate;
			seen.exhausted = res_ch.exhausted;
			seen.last      = res_ch.last_of_point;
			book.check_coordinate(seen);
		end
		if (hold_left > 0) begin
			res_ch.ready <= 1'b0;
			hold_left--;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) || psel) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int seg;
		int dims_plan [6];
		dims_plan          = '{3, 0, 15, 1, 6, 8};
		book               = new();
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.req_type    = '0;
		req_ch.dim_select  = '0;
		req_ch.poly_degree = '0;
		req_ch.poly_coeff  = '0;
		req_ch.init_index  = '0;
		req_ch.init_value  = '0;
		req_ch.skip_amount = '0;
		res_ch.ready       = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		send_idle_pct      = 0;
		recv_stall_pct     = 0;
		hold_left          = 0;
		idle_cycles        = 0;
		items_sent         = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		next_point();
		// dimension 0 is fixed: these are dropped
		send_request(REQ_SET_POLY, 0, 5, 3, 0, 0, 0);
		send_request(REQ_LOAD_INIT, 0, 0, 0, 0, 1, 0);
		send_request(REQ_BUILD, 0, 0, 0, 0, 0, 0);
		// x + 1
		send_request(REQ_SET_POLY, 1, 1, 0, 0, 0, 0);
		send_request(REQ_LOAD_INIT, 1, 0, 0, 0, 1, 0);
		send_request(REQ_BUILD, 1, 0, 0, 0, 0, 0);
		// x^2 + x + 1
		send_request(REQ_SET_POLY, 2, 2, 1, 0, 0, 0);
		send_request(REQ_LOAD_INIT, 2, 0, 0, 0, 1, 0);
		send_request(REQ_LOAD_INIT, 2, 0, 0, 1, 3, 0);
		send_request(REQ_BUILD, 2, 0, 0, 0, 0, 0);
		// degree clamps to the max, widest values, indexes past the table dropped
		send_request(REQ_SET_POLY, 7, 31, 32'h1_FFFF, 0, 0, 0);
		send_request(REQ_LOAD_INIT, 7, 0, 0, 17, 32'h3_FFFF, 0);
		send_request(REQ_LOAD_INIT, 7, 0, 0, 0, 0, 0);
		send_request(REQ_LOAD_INIT, 7, 0, 0, 18, 32'h3_FFFF, 0);
		send_request(REQ_LOAD_INIT, 7, 0, 0, 31, 32'h3_FFFF, 0);
		send_request(REQ_BUILD, 7, 0, 0, 0, 0, 0);
		// degree zero: build is a no-op
		send_request(REQ_SET_POLY, 4, 0, 0, 0, 0, 0);
		send_request(REQ_LOAD_INIT, 4, 0, 0, 0, 1, 0);
		send_request(REQ_BUILD, 4, 0, 0, 0, 0, 0);
		send_request(REQ_RSVD_5, 1, 1, 1, 1, 1, 1);
		send_request(REQ_RSVD_6, 2, 2, 2, 2, 2, 2);
		send_request(REQ_RSVD_7, 3, 3, 3, 3, 3, 3);
		skip_by(0);
		next_point();
		next_point();

		for (seg = 0; seg < 6; seg++) begin
			settle();
			write_reg(ADDR_DIMS_IN_USE, dims_plan[seg]);
			send_idle_pct  = (seg < 2) ? 34 : (seg < 4) ? 79 : 0;
			recv_stall_pct = (seg < 2) ? 79 : (seg < 4) ? 34 : 0;
			if (seg == 5) begin
				// carry chain up through the top bit
				skip_by(32'h7FFF_FFFC - book.count);
				repeat (8) next_point();
				// output stalled while requests keep coming
				hold_left = 400;
				repeat (6) next_point();
				settle();
			end
			run_random(SEG_ITEMS);
		end

		// run into the end of the sequence, then saturate with a full skip
		skip_by(32'hFFFF_FFF0 - book.count);
		repeat (20) next_point();
		skip_by(32'hFFFF_FFFF);
		repeat (2) next_point();
		settle();

		if (book.errors == 0 && book.pending.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/spg_pkg.sv
rtl/spg_req_if.sv
rtl/spg_res_if.sv
rtl/spg_cell.sv
rtl/spg_cfg.sv
rtl/sobol_point_generator.sv
tb/sv/tb_sobol_point_generator.sv
